// ===== design/lpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator: shared package
// Widths, register indexes, reset values and the types that pass between
// the front end, the pair queue, the divider and the back end.
// ----------------------------------------------------------------------------
package lpfa_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_W       = 24;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 3;
    localparam int DISP_W      = POS_W + 2;
    localparam int FULL_W      = 2 * DISP_W + 2;
    localparam int DQ_W        = FULL_W - FRAC_BITS;
    localparam int ACC_W       = 48;
    localparam int DIVD_W      = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACC_W-1:0] LIM = {1'b0, {(ACC_W-1){1'b1}}};

    localparam logic [IDX_W-1:0] REG_BOX_LENGTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF_SQUARED = 3'd1;
    localparam logic [IDX_W-1:0] REG_SIGMA_SQUARED  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ENERGY_SHIFT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_FORCE_SCALE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_ENERGY_SCALE   = 3'd5;

    localparam logic [POS_W-1:0]         RST_BOX_LENGTH     = 24'hFF_FFFF;
    localparam logic [DATA_W-1:0]        RST_CUTOFF_SQUARED = 32'd6553600;
    localparam logic [DATA_W-1:0]        RST_SIGMA_SQUARED  = 32'd65536;
    localparam logic signed [DATA_W-1:0] RST_ENERGY_SHIFT   = 32'sd0;
    localparam logic [DATA_W-1:0]        RST_FORCE_SCALE    = 32'd1572864;
    localparam logic [DATA_W-1:0]        RST_ENERGY_SCALE   = 32'd131072;

    typedef struct packed {
        logic [POS_W-1:0]         box_length;
        logic [DATA_W-1:0]        cutoff_squared;
        logic [DATA_W-1:0]        sigma_squared;
        logic signed [DATA_W-1:0] energy_shift;
        logic [DATA_W-1:0]        force_scale;
        logic [DATA_W-1:0]        energy_scale;
    } t_cfg;

    typedef struct packed {
        logic signed [DISP_W-1:0] d_x;
        logic signed [DISP_W-1:0] d_y;
        logic signed [DISP_W-1:0] d_z;
        logic [DQ_W-1:0]          dq;
        logic                     in_cutoff;
        logic                     last;
    } t_pair;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DQ_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_MSQ, S_M6, S_M12, S_ACC_E, S_DIV2,
        S_MFX, S_MFY, S_MFZ, S_EX, S_EY, S_EZ, S_EE, S_OUT
    } t_back_state;

endpackage

// ===== design/lpfa_front.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator: front end
// Three-stage pipeline: minimum image, squares, squared distance and cutoff.
// ----------------------------------------------------------------------------
module lpfa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lpfa_pkg::POS_W-1:0]  i_centre_x,
    input  logic [lpfa_pkg::POS_W-1:0]  i_centre_y,
    input  logic [lpfa_pkg::POS_W-1:0]  i_centre_z,
    input  logic [lpfa_pkg::POS_W-1:0]  i_other_x,
    input  logic [lpfa_pkg::POS_W-1:0]  i_other_y,
    input  logic [lpfa_pkg::POS_W-1:0]  i_other_z,
    input  logic                        i_has_pair,
    input  logic                        i_last_neighbor,
    input  lpfa_pkg::t_cfg              i_cfg,
    output logic                        o_pair_valid,
    input  logic                        i_pair_ready,
    output lpfa_pkg::t_pair             o_pair
);
    import lpfa_pkg::*;

    function automatic logic signed [DISP_W-1:0] min_image(
        input logic [POS_W-1:0] c,
        input logic [POS_W-1:0] o,
        input logic [POS_W-1:0] len
    );
        logic signed [DISP_W-1:0] v;
        logic signed [DISP_W-1:0] l;
        logic signed [DISP_W:0]   v2;
        logic signed [DISP_W:0]   l2;
        v  = $signed(DISP_W'(c)) - $signed(DISP_W'(o));
        l  = $signed(DISP_W'(len));
        v2 = $signed({v, 1'b0});
        l2 = (DISP_W+1)'(l);
        if (v2 >= l2) begin
            return v - l;
        end else if (v2 < -l2) begin
            return v + l;
        end
        return v;
    endfunction

    logic                        w_adv;
    logic                        r_a_v, r_b_v, r_c_v;
    logic signed [DISP_W-1:0]    r_a_dx, r_a_dy, r_a_dz;
    logic                        r_a_has, r_a_last;
    logic signed [DISP_W-1:0]    r_b_dx, r_b_dy, r_b_dz;
    logic [2*DISP_W-1:0]         r_b_sqx, r_b_sqy, r_b_sqz;
    logic                        r_b_has, r_b_last;
    logic signed [2*DISP_W-1:0]  w_sqx, w_sqy, w_sqz;
    logic [FULL_W-1:0]           w_full;
    logic [FULL_W-1:0]           w_cut;
    t_pair                       r_c;

    // The whole pipeline moves together whenever its last stage can drain.
    assign w_adv   = !r_c_v || i_pair_ready;
    assign o_ready = w_adv;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;
    assign w_sqz = r_a_dz * r_a_dz;

    assign w_full = FULL_W'(r_b_sqx) + FULL_W'(r_b_sqy) + FULL_W'(r_b_sqz);
    assign w_cut  = FULL_W'(i_cfg.cutoff_squared) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_dx   <= min_image(i_centre_x, i_other_x, i_cfg.box_length);
            r_a_dy   <= min_image(i_centre_y, i_other_y, i_cfg.box_length);
            r_a_dz   <= min_image(i_centre_z, i_other_z, i_cfg.box_length);
            r_a_has  <= i_has_pair;
            r_a_last <= i_last_neighbor;

            r_b_dx   <= r_a_dx;
            r_b_dy   <= r_a_dy;
            r_b_dz   <= r_a_dz;
            r_b_sqx  <= $unsigned(w_sqx);
            r_b_sqy  <= $unsigned(w_sqy);
            r_b_sqz  <= $unsigned(w_sqz);
            r_b_has  <= r_a_has;
            r_b_last <= r_a_last;

            r_c.d_x       <= r_b_dx;
            r_c.d_y       <= r_b_dy;
            r_c.d_z       <= r_b_dz;
            r_c.dq        <= w_full[FULL_W-1:FRAC_BITS];
            r_c.in_cutoff <= r_b_has && (w_full < w_cut);
            r_c.last      <= r_b_last;
        end
    end

    assign o_pair_valid = r_c_v;
    assign o_pair       = r_c;

endmodule

// ===== design/lpfa_queue.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator: pair queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lpfa_queue #(
    parameter int DEPTH = lpfa_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpfa_pkg::t_pair i_item,
    output logic            o_ready,
    output logic            o_valid,
    output lpfa_pkg::t_pair o_item,
    input  logic            i_pop
);
    import lpfa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pair             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== design/lpfa_divu.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator: divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpfa_divu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpfa_pkg::t_div_req i_req,
    output lpfa_pkg::t_div_rsp o_rsp
);
    import lpfa_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DQ_W-1:0]     r_rem, n_rem;
    logic [DQ_W-1:0]     r_div, n_div;
    logic [DIVD_W-1:0]   r_quo, n_quo;
    logic [DQ_W:0]       w_trial;
    logic                w_ge;
    logic [DQ_W:0]       w_diff;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_quo  = i_req.dividend;
        end else if (r_busy) begin
            n_rem = w_diff[DQ_W-1:0];
            n_quo = {r_quo[DIVD_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider reports done while still busy");

endmodule

// ===== design/lpfa_back.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator: back end
// Sequencer that evaluates one pair with the shared divider and a
// four-step multiplier, accumulates, and produces the scaled results.
// ----------------------------------------------------------------------------
module lpfa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pair_valid,
    input  lpfa_pkg::t_pair                   i_pair,
    output logic                              o_pair_pop,
    input  lpfa_pkg::t_cfg                    i_cfg,
    output lpfa_pkg::t_div_req                o_div_req,
    input  lpfa_pkg::t_div_rsp                i_div_rsp,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_x,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_y,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_z,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_energy_part
);
    import lpfa_pkg::*;

    localparam int HALF = ACC_W / 2;

    function automatic logic [ACC_W-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag_disp(input logic signed [DISP_W-1:0] v);
        return v[DISP_W-1] ? ACC_W'($unsigned(-v)) : ACC_W'($unsigned(v));
    endfunction

    function automatic logic signed [ACC_W:0] with_sign(
        input logic [ACC_W-1:0] m,
        input logic             neg
    );
        logic signed [ACC_W:0] p;
        p = $signed({1'b0, m});
        return neg ? -p : p;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] s);
        if (s[ACC_W+1:ACC_W-1] == 3'b000 || s[ACC_W+1:ACC_W-1] == 3'b111) begin
            return s[ACC_W-1:0];
        end
        return s[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W:0] v);
        if (&v[ACC_W:DATA_W-1] || ~|v[ACC_W:DATA_W-1]) begin
            return v[DATA_W-1:0];
        end
        return v[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic [ACC_W-1:0] clamp_quo(input logic [DIVD_W-1:0] q);
        return (q > DIVD_W'(LIM)) ? LIM : q[ACC_W-1:0];
    endfunction

    t_back_state               r_state, n_state;
    logic signed [DISP_W-1:0]  r_dx, r_dy, r_dz, n_dx, n_dy, n_dz;
    logic [DQ_W-1:0]           r_dq, n_dq;
    logic                      r_last, n_last;
    logic [ACC_W-1:0]          r_sr2, n_sr2, r_t, n_t, r_sr6, n_sr6, r_sr12, n_sr12;
    logic [ACC_W-1:0]          r_fm, n_fm;
    logic                      r_neg, n_neg;
    logic signed [ACC_W-1:0]   r_fx, r_fy, r_fz, r_e, n_fx, n_fy, n_fz, n_e;
    logic signed [DATA_W-1:0]  r_rx, r_ry, r_rz, r_re, n_rx, n_ry, n_rz, n_re;
    logic signed [DATA_W-1:0]  r_ox, r_oy, r_oz, r_oe, n_ox, n_oy, n_oz, n_oe;
    logic                      r_o_valid, n_o_valid;
    logic [1:0]                r_mcnt, n_mcnt;
    logic [2*ACC_W-1:0]        r_macc, n_macc;

    logic [ACC_W-1:0]          w_ma, w_mb;
    logic [HALF-1:0]           w_pa, w_pb;
    logic [ACC_W-1:0]          w_pp;
    logic [2*ACC_W-1:0]        w_pp_sh;
    logic [2*ACC_W-FRAC_BITS-1:0] w_mhi;
    logic [ACC_W-1:0]          w_mres;
    logic                      w_in_mul;
    logic                      w_mlast;
    logic                      w_out_free;
    logic signed [ACC_W+1:0]   w_energy;
    logic signed [ACC_W+1:0]   w_num;
    logic [ACC_W+1:0]          w_nm;

    assign w_in_mul = (r_state == S_MSQ) || (r_state == S_M6) || (r_state == S_M12)
                   || (r_state == S_MFX) || (r_state == S_MFY) || (r_state == S_MFZ)
                   || (r_state == S_EX)  || (r_state == S_EY)  || (r_state == S_EZ)
                   || (r_state == S_EE);
    assign w_mlast    = r_mcnt == 2'd3;
    assign w_out_free = !r_o_valid || i_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_MSQ:   begin w_ma = r_sr2;      w_mb = r_sr2;  end
            S_M6:    begin w_ma = r_t;        w_mb = r_sr2;  end
            S_M12:   begin w_ma = r_sr6;      w_mb = r_sr6;  end
            S_MFX:   begin w_ma = r_fm;       w_mb = mag_disp(r_dx); end
            S_MFY:   begin w_ma = r_fm;       w_mb = mag_disp(r_dy); end
            S_MFZ:   begin w_ma = r_fm;       w_mb = mag_disp(r_dz); end
            S_EX:    begin w_ma = mag_acc(r_fx); w_mb = ACC_W'(i_cfg.force_scale);  end
            S_EY:    begin w_ma = mag_acc(r_fy); w_mb = ACC_W'(i_cfg.force_scale);  end
            S_EZ:    begin w_ma = mag_acc(r_fz); w_mb = ACC_W'(i_cfg.force_scale);  end
            S_EE:    begin w_ma = mag_acc(r_e);  w_mb = ACC_W'(i_cfg.energy_scale); end
            default: begin w_ma = '0;         w_mb = '0;     end
        endcase
    end

    // One half-width partial product per cycle, low halves first.
    assign w_pa = r_mcnt[1] ? w_ma[ACC_W-1:HALF] : w_ma[HALF-1:0];
    assign w_pb = r_mcnt[0] ? w_mb[ACC_W-1:HALF] : w_mb[HALF-1:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        unique case (r_mcnt)
            2'd0:    w_pp_sh = (2*ACC_W)'(w_pp);
            2'd3:    w_pp_sh = (2*ACC_W)'(w_pp) << ACC_W;
            default: w_pp_sh = (2*ACC_W)'(w_pp) << HALF;
        endcase
    end

    assign n_macc = ((r_mcnt == 2'd0) ? '0 : r_macc) + w_pp_sh;
    assign w_mhi  = n_macc[2*ACC_W-1:FRAC_BITS];
    assign w_mres = (w_mhi > (2*ACC_W-FRAC_BITS)'(LIM)) ? LIM : w_mhi[ACC_W-1:0];
    assign n_mcnt = w_in_mul ? r_mcnt + 1'b1 : 2'd0;

    assign w_energy = $signed({2'b00, r_sr12}) - $signed({2'b00, r_sr6})
                    - (ACC_W+2)'(i_cfg.energy_shift);
    assign w_num    = $signed({1'b0, r_sr12, 1'b0}) - $signed({2'b00, r_sr6});
    assign w_nm     = w_num[ACC_W+1] ? $unsigned(-w_num) : $unsigned(w_num);

    always_comb begin
        n_state   = r_state;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_dz      = r_dz;
        n_dq      = r_dq;
        n_last    = r_last;
        n_sr2     = r_sr2;
        n_t       = r_t;
        n_sr6     = r_sr6;
        n_sr12    = r_sr12;
        n_fm      = r_fm;
        n_neg     = r_neg;
        n_fx      = r_fx;
        n_fy      = r_fy;
        n_fz      = r_fz;
        n_e       = r_e;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_rz      = r_rz;
        n_re      = r_re;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oz      = r_oz;
        n_oe      = r_oe;
        n_o_valid = r_o_valid && !i_ready;
        o_pair_pop         = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = DIVD_W'(i_cfg.sigma_squared) << FRAC_BITS;
        o_div_req.divisor  = i_pair.dq;

        unique case (r_state)
            S_IDLE: begin
                if (i_pair_valid) begin
                    o_pair_pop = 1'b1;
                    n_dx   = i_pair.d_x;
                    n_dy   = i_pair.d_y;
                    n_dz   = i_pair.d_z;
                    n_dq   = i_pair.dq;
                    n_last = i_pair.last;
                    if (i_pair.in_cutoff) begin
                        if (i_pair.dq == '0) begin
                            n_sr2   = LIM;
                            n_state = S_MSQ;
                        end else begin
                            o_div_req.start = 1'b1;
                            n_state = S_DIV1;
                        end
                    end else if (i_pair.last) begin
                        n_state = S_EX;
                    end
                end
            end
            S_DIV1: begin
                if (i_div_rsp.done) begin
                    n_sr2   = clamp_quo(i_div_rsp.quotient);
                    n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                if (w_mlast) begin
                    n_t     = w_mres;
                    n_state = S_M6;
                end
            end
            S_M6: begin
                if (w_mlast) begin
                    n_sr6   = w_mres;
                    n_state = S_M12;
                end
            end
            S_M12: begin
                if (w_mlast) begin
                    n_sr12  = w_mres;
                    n_state = S_ACC_E;
                end
            end
            S_ACC_E: begin
                n_e   = sat_acc((ACC_W+2)'(r_e) + (ACC_W+2)'(sat_acc(w_energy)));
                n_neg = w_num[ACC_W+1];
                if (r_dq == '0) begin
                    n_fm    = (w_num == '0) ? '0 : LIM;
                    n_state = S_MFX;
                end else begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = DIVD_W'(w_nm) << FRAC_BITS;
                    o_div_req.divisor  = r_dq;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_div_rsp.done) begin
                    n_fm    = clamp_quo(i_div_rsp.quotient);
                    n_state = S_MFX;
                end
            end
            S_MFX: begin
                if (w_mlast) begin
                    n_fx = sat_acc((ACC_W+2)'(r_fx)
                         + (ACC_W+2)'(with_sign(w_mres, r_neg ^ r_dx[DISP_W-1])));
                    n_state = S_MFY;
                end
            end
            S_MFY: begin
                if (w_mlast) begin
                    n_fy = sat_acc((ACC_W+2)'(r_fy)
                         + (ACC_W+2)'(with_sign(w_mres, r_neg ^ r_dy[DISP_W-1])));
                    n_state = S_MFZ;
                end
            end
            S_MFZ: begin
                if (w_mlast) begin
                    n_fz = sat_acc((ACC_W+2)'(r_fz)
                         + (ACC_W+2)'(with_sign(w_mres, r_neg ^ r_dz[DISP_W-1])));
                    n_state = r_last ? S_EX : S_IDLE;
                end
            end
            S_EX: begin
                if (w_mlast) begin
                    n_rx    = sat_out(with_sign(w_mres, r_fx[ACC_W-1]));
                    n_state = S_EY;
                end
            end
            S_EY: begin
                if (w_mlast) begin
                    n_ry    = sat_out(with_sign(w_mres, r_fy[ACC_W-1]));
                    n_state = S_EZ;
                end
            end
            S_EZ: begin
                if (w_mlast) begin
                    n_rz    = sat_out(with_sign(w_mres, r_fz[ACC_W-1]));
                    n_state = S_EE;
                end
            end
            S_EE: begin
                if (w_mlast) begin
                    n_re    = sat_out(with_sign(w_mres, r_e[ACC_W-1]));
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ox      = r_rx;
                    n_oy      = r_ry;
                    n_oz      = r_rz;
                    n_oe      = r_re;
                    n_o_valid = 1'b1;
                    n_fx      = '0;
                    n_fy      = '0;
                    n_fz      = '0;
                    n_e       = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mcnt    <= 2'd0;
            r_o_valid <= 1'b0;
            r_fx      <= '0;
            r_fy      <= '0;
            r_fz      <= '0;
            r_e       <= '0;
        end else begin
            r_state   <= n_state;
            r_mcnt    <= n_mcnt;
            r_o_valid <= n_o_valid;
            r_fx      <= n_fx;
            r_fy      <= n_fy;
            r_fz      <= n_fz;
            r_e       <= n_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_dz   <= n_dz;
        r_dq   <= n_dq;
        r_last <= n_last;
        r_sr2  <= n_sr2;
        r_t    <= n_t;
        r_sr6  <= n_sr6;
        r_sr12 <= n_sr12;
        r_fm   <= n_fm;
        r_neg  <= n_neg;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_rz   <= n_rz;
        r_re   <= n_re;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_oz   <= n_oz;
        r_oe   <= n_oe;
        r_macc <= n_macc;
    end

    assign o_valid       = r_o_valid;
    assign o_force_x     = r_ox;
    assign o_force_y     = r_oy;
    assign o_force_z     = r_oz;
    assign o_energy_part = r_oe;

    a_mcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_mul |-> r_mcnt == 2'd0)
        else $error("multiplier step count left running outside a multiply");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free)
        |=> (r_fx == '0 && r_fy == '0 && r_fz == '0 && r_e == '0 && r_o_valid))
        else $error("sums not cleared when the result was loaded");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output step");

endmodule

// ===== design/lj_pair_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair force accumulator
// Shifted-cutoff Lennard-Jones forces and energy, summed per particle.
// ----------------------------------------------------------------------------
// Each input transfer carries one neighbour pair (centre and neighbour
// positions, Q8.16) plus the has_pair and last_neighbor flags. The front end
// forms the minimum-image displacement, the squared distance and the cutoff
// decision in a three-stage pipeline and writes the result into a two-entry
// queue; it takes a new transfer every cycle while the queue has room.
// The back end works on one pair at a time. A pair inside the cutoff takes
// two passes of the bit-serial divider (sigma^2/r^2 and the force ratio),
// six runs of the shared multiplier, a pop step and an energy step; at zero
// distance the divider is skipped. A pair outside the cutoff, or an empty
// marker, is popped with no arithmetic. The transfer marked last_neighbor
// then runs the four scaled products and places one result in the output
// register, which frees the back end once the previous result has gone.
// If the output receiver stalls, the result stays in the output register,
// the back end waits with the next result, and the queue and front end fill
// and then drop ready. Reset (synchronous, active low) clears the sums and
// all handshake state and loads the documented register defaults.
// Configuration writes take effect at once and are expected while idle.
// ----------------------------------------------------------------------------
module lj_pair_force_accumulator #(
    parameter int QUEUE_DEPTH = lpfa_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [lpfa_pkg::POS_W-1:0]         i_centre_x,
    input  logic [lpfa_pkg::POS_W-1:0]         i_centre_y,
    input  logic [lpfa_pkg::POS_W-1:0]         i_centre_z,
    input  logic [lpfa_pkg::POS_W-1:0]         i_other_x,
    input  logic [lpfa_pkg::POS_W-1:0]         i_other_y,
    input  logic [lpfa_pkg::POS_W-1:0]         i_other_z,
    input  logic                               i_has_pair,
    input  logic                               i_last_neighbor,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_x,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_y,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_force_z,
    output logic signed [lpfa_pkg::DATA_W-1:0] o_energy_part,
    input  logic                               i_cfg_we,
    input  logic [lpfa_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [lpfa_pkg::DATA_W-1:0]        i_cfg_data
);
    import lpfa_pkg::*;

    t_cfg     r_cfg;
    logic     w_front_valid;
    t_pair    w_front_pair;
    logic     w_q_ready;
    logic     w_q_valid;
    t_pair    w_q_item;
    logic     w_q_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // Register file. Unknown indexes are simply ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_length     <= RST_BOX_LENGTH;
            r_cfg.cutoff_squared <= RST_CUTOFF_SQUARED;
            r_cfg.sigma_squared  <= RST_SIGMA_SQUARED;
            r_cfg.energy_shift   <= RST_ENERGY_SHIFT;
            r_cfg.force_scale    <= RST_FORCE_SCALE;
            r_cfg.energy_scale   <= RST_ENERGY_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BOX_LENGTH:     r_cfg.box_length     <= i_cfg_data[POS_W-1:0];
                REG_CUTOFF_SQUARED: r_cfg.cutoff_squared <= i_cfg_data;
                REG_SIGMA_SQUARED:  r_cfg.sigma_squared  <= i_cfg_data;
                REG_ENERGY_SHIFT:   r_cfg.energy_shift   <= $signed(i_cfg_data);
                REG_FORCE_SCALE:    r_cfg.force_scale    <= i_cfg_data;
                REG_ENERGY_SCALE:   r_cfg.energy_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lpfa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_centre_x      (i_centre_x),
        .i_centre_y      (i_centre_y),
        .i_centre_z      (i_centre_z),
        .i_other_x       (i_other_x),
        .i_other_y       (i_other_y),
        .i_other_z       (i_other_z),
        .i_has_pair      (i_has_pair),
        .i_last_neighbor (i_last_neighbor),
        .i_cfg           (r_cfg),
        .o_pair_valid    (w_front_valid),
        .i_pair_ready    (w_q_ready),
        .o_pair          (w_front_pair)
    );

    lpfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid && w_q_ready),
        .i_item  (w_front_pair),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    lpfa_divu u_divu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lpfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pair_valid  (w_q_valid),
        .i_pair        (w_q_item),
        .o_pair_pop    (w_q_pop),
        .i_cfg         (r_cfg),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_force_x     (o_force_x),
        .o_force_y     (o_force_y),
        .o_force_z     (o_force_z),
        .o_energy_part (o_energy_part)
    );

endmodule
